/* rtl/core/circle_canvas_painter_defines.svh */
// ----------------------------------------------------------------------------
// Circle canvas painter assertion macros
// Shared assertion forms for the canvas painter checkers.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CANVAS_PAINTER_DEFINES_SVH
`define CIRCLE_CANVAS_PAINTER_DEFINES_SVH

// Checked on every rising edge of clk outside of reset.
`define CCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ccp_pkg.sv */
// ----------------------------------------------------------------------------
// Circle canvas painter package
// Command, status and register codes, state encoding and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccp_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_SHAPE = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_BG     = 2'd2;

  localparam logic [7:0] KIND_FILLED  = 8'h43;
  localparam logic [7:0] KIND_OUTLINE = 8'h63;

  localparam logic [8:0] RESET_WIDTH  = 9'd1;
  localparam logic [8:0] RESET_HEIGHT = 9'd1;
  localparam logic [7:0] RESET_BG     = 8'd32;

  localparam int COORD_W = 32;
  localparam int SQ_W    = 64;
  localparam int CFG_W   = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] operand;
  } sq_req_t;

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] square;
  } sq_rsp_t;

endpackage

/* rtl/core/ccp_ifs.sv */
// ----------------------------------------------------------------------------
// Circle canvas painter channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ccp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [7:0]                          shape_kind;
  logic signed [ccp_pkg::COORD_W-1:0]  center_x;
  logic signed [ccp_pkg::COORD_W-1:0]  center_y;
  logic signed [ccp_pkg::COORD_W-1:0]  radius;
  logic [7:0]                          paint_char;
  logic [7:0]                          read_x;
  logic [7:0]                          read_y;

  modport source (
    output valid, command, shape_kind, center_x, center_y, radius, paint_char,
           read_x, read_y,
    input  ready
  );
  modport sink (
    input  valid, command, shape_kind, center_x, center_y, radius, paint_char,
           read_x, read_y,
    output ready
  );
endinterface

interface ccp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_char;

  modport source (output valid, status, pixel_char, input ready);
  modport sink (input valid, status, pixel_char, output ready);
endinterface

/* rtl/core/ccp_square.sv */
// ----------------------------------------------------------------------------
// Circle canvas painter squarer
// Squares a 32-bit unsigned value with one 16x16 multiplier, summing weighted partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccp_square (
  input  logic             clk,
  input  logic             rst_n,
  input  ccp_pkg::sq_req_t req,
  output ccp_pkg::sq_rsp_t rsp
);

  logic [ccp_pkg::COORD_W-1:0] op_r;
  logic [1:0]                  step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [31:0]                 prod_r;
  logic [ccp_pkg::SQ_W-1:0]    acc_r;
  logic [15:0]                 fa;
  logic [15:0]                 fb;
  logic [ccp_pkg::SQ_W-1:0]    term;

  // The product of one step is added in the next one, with its weight.
  always_comb begin
    case (step_r)
      2'd0: begin
        fa = op_r[15:0];
        fb = op_r[15:0];
      end
      2'd1: begin
        fa = op_r[31:16];
        fb = op_r[15:0];
      end
      default: begin
        fa = op_r[31:16];
        fb = op_r[31:16];
      end
    endcase
    case (step_r)
      2'd1:    term = ccp_pkg::SQ_W'(prod_r);
      2'd2:    term = ccp_pkg::SQ_W'(prod_r) << 17;
      2'd3:    term = ccp_pkg::SQ_W'(prod_r) << 32;
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= !req.start && busy_r && (step_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.operand;
      acc_r <= '0;
    end else if (busy_r) begin
      prod_r <= fa * fb;
      acc_r  <= acc_r + term;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.square = acc_r;

endmodule

/* rtl/core/circle_canvas_painter.sv */
// ----------------------------------------------------------------------------
// Circle canvas painter
// Byte canvas in a synchronous memory with clear, circle draw and pixel read.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake      Contents
//   in_ch     in   valid/ready    command, shape, centre, radius, paint, read xy
//   out_ch    out  valid/ready    status, pixel_char
//   cfg_*     in   cfg_we only    width, height, background byte
//
// Clear writes all MAX_WIDTH*MAX_HEIGHT cells with the background, one memory
// write per cycle. Draw first squares centre x, centre y, radius and inner radius
// in turn, then scans width*height pixels, one pixel per cycle through the single
// write port. A rejected request skips the memory access.
// A new request is taken once the previous one has reached the result register.
// Reset leaves the canvas contents undefined until the first clear.
//
`timescale 1ns / 1ps

module circle_canvas_painter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ccp_pkg::CFG_W-1:0] cfg_wdata,
  ccp_cmd_if.sink                   in_ch,
  ccp_res_if.source                 out_ch
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int HW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int EW = 34;
  localparam int SW = 66;

  ccp_pkg::state_t state_r;
  ccp_pkg::state_t state_nxt;

  logic [ccp_pkg::CFG_W-1:0] cfg_width_r;
  logic [ccp_pkg::CFG_W-1:0] cfg_height_r;
  logic [7:0]                cfg_bg_r;

  logic                     outline_r;
  logic [7:0]               paint_r;
  logic [AW-1:0]            rd_addr_r;
  logic [1:0]               res_status_r;
  logic                     res_is_read_r;
  logic [31:0]              cx_abs_r;
  logic [31:0]              cy_abs_r;
  logic [31:0]              r_abs_r;
  logic [31:0]              rm_abs_r;
  logic                     rm_ok_r;
  logic signed [EW-1:0]     ex_init_r;
  logic signed [EW-1:0]     ex_r;
  logic signed [EW-1:0]     ey_r;
  logic [ccp_pkg::SQ_W-1:0] cx2_r;
  logic [ccp_pkg::SQ_W-1:0] r2_r;
  logic [ccp_pkg::SQ_W-1:0] rm2_r;
  logic [ccp_pkg::SQ_W-1:0] dx2_r;
  logic [ccp_pkg::SQ_W-1:0] dy2_r;
  logic [ccp_pkg::SQ_W-1:0] dx2_nxt;
  logic [ccp_pkg::SQ_W-1:0] dy2_nxt;
  logic signed [SW-1:0]     dx2_sum;
  logic signed [SW-1:0]     dy2_sum;
  logic [XW-1:0]            x_r;
  logic [YW-1:0]            y_r;
  logic [AW-1:0]            row_base_r;
  logic [AW-1:0]            clr_addr_r;
  logic [1:0]               sq_idx_r;
  logic                     sq_go_r;

  logic                     p_valid_r;
  logic [AW-1:0]            p_addr_r;
  logic [ccp_pkg::SQ_W:0]   d2_r;

  logic [7:0]               canvas_mem [DEPTH];
  logic [7:0]               rd_data_r;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic [7:0]               out_pixel_r;

  ccp_pkg::sq_req_t sq_req;
  ccp_pkg::sq_rsp_t sq_rsp;

  logic [DW-1:0]            w_use;
  logic [HW-1:0]            h_use;
  logic                     in_fire;
  logic                     in_ready;
  logic                     kind_ok;
  logic                     rad_ok;
  logic                     draw_ok;
  logic                     rd_in_range;
  logic signed [31:0]       rm_calc;
  logic                     row_end;
  logic                     last_px;
  logic                     paint_hit;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     mem_re;
  logic                     res_load;

  ccp_square u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    w_use = (DW'(cfg_width_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(cfg_width_r);
    h_use = (HW'(cfg_height_r) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_height_r);
    in_fire = in_ch.valid && in_ready;
    kind_ok = (in_ch.shape_kind == ccp_pkg::KIND_FILLED) ||
              (in_ch.shape_kind == ccp_pkg::KIND_OUTLINE);
    rad_ok = !in_ch.radius[31] && (in_ch.radius != 32'sd0);
    draw_ok = kind_ok && rad_ok;
    rd_in_range = (DW'(in_ch.read_x) < w_use) && (HW'(in_ch.read_y) < h_use);
    rm_calc = in_ch.radius - 32'sd256;
    row_end = (DW'(x_r) == w_use - DW'(1));
    last_px = row_end && (HW'(y_r) == h_use - HW'(1));
    paint_hit = p_valid_r && (d2_r <= {1'b0, r2_r}) &&
                !(outline_r && rm_ok_r && (d2_r <= {1'b0, rm2_r}));
    dx2_sum = $signed({2'b00, dx2_r}) + (SW'(ex_r) <<< 9) + 66'sd65536;
    dy2_sum = $signed({2'b00, dy2_r}) + (SW'(ey_r) <<< 9) + 66'sd65536;
    dx2_nxt = dx2_sum[ccp_pkg::SQ_W-1:0];
    dy2_nxt = dy2_sum[ccp_pkg::SQ_W-1:0];
    sq_req.start = sq_go_r;
    case (sq_idx_r)
      2'd0:    sq_req.operand = cx_abs_r;
      2'd1:    sq_req.operand = cy_abs_r;
      2'd2:    sq_req.operand = r_abs_r;
      default: sq_req.operand = rm_abs_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.command)
            ccp_pkg::CMD_CLEAR: state_nxt = ccp_pkg::ST_CLEAR;
            ccp_pkg::CMD_DRAW:  state_nxt = draw_ok ? ccp_pkg::ST_SETUP : ccp_pkg::ST_RESP;
            ccp_pkg::CMD_READ:  state_nxt = rd_in_range ? ccp_pkg::ST_READ : ccp_pkg::ST_RESP;
            default:            state_nxt = ccp_pkg::ST_RESP;
          endcase
        end
      end
      ccp_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ccp_pkg::ST_RESP;
      end
      ccp_pkg::ST_SETUP: begin
        if (sq_rsp.done && (sq_idx_r == 2'd3)) begin
          if ((w_use == '0) || (h_use == '0)) state_nxt = ccp_pkg::ST_RESP;
          else                                state_nxt = ccp_pkg::ST_DRAW;
        end
      end
      ccp_pkg::ST_DRAW: begin
        if (last_px) state_nxt = ccp_pkg::ST_DRAIN;
      end
      ccp_pkg::ST_DRAIN: state_nxt = ccp_pkg::ST_RESP;
      ccp_pkg::ST_READ:  state_nxt = ccp_pkg::ST_RESP;
      ccp_pkg::ST_RESP: begin
        if (res_load) state_nxt = ccp_pkg::ST_IDLE;
      end
      default: state_nxt = ccp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = p_addr_r;
    mem_wdata = paint_r;
    mem_re    = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      ccp_pkg::ST_IDLE: in_ready = 1'b1;
      ccp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = cfg_bg_r;
      end
      ccp_pkg::ST_DRAW, ccp_pkg::ST_DRAIN: mem_we = paint_hit;
      ccp_pkg::ST_READ: mem_re = 1'b1;
      ccp_pkg::ST_RESP: res_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccp_pkg::ST_IDLE;
      cfg_width_r  <= ccp_pkg::RESET_WIDTH;
      cfg_height_r <= ccp_pkg::RESET_HEIGHT;
      cfg_bg_r     <= ccp_pkg::RESET_BG;
      out_valid_r  <= 1'b0;
      p_valid_r    <= 1'b0;
      sq_go_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ccp_pkg::CFG_IDX_WIDTH:  cfg_width_r  <= cfg_wdata;
          ccp_pkg::CFG_IDX_HEIGHT: cfg_height_r <= cfg_wdata;
          ccp_pkg::CFG_IDX_BG:     cfg_bg_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (res_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      p_valid_r <= (state_r == ccp_pkg::ST_DRAW);
      sq_go_r   <= (in_fire && (in_ch.command == ccp_pkg::CMD_DRAW) && draw_ok) ||
                   (sq_rsp.done && (sq_idx_r != 2'd3));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      outline_r     <= (in_ch.shape_kind == ccp_pkg::KIND_OUTLINE);
      paint_r       <= in_ch.paint_char;
      rd_addr_r     <= AW'(in_ch.read_y) * AW'(MAX_WIDTH) + AW'(in_ch.read_x);
      res_is_read_r <= (in_ch.command == ccp_pkg::CMD_READ) && rd_in_range;
      cx_abs_r      <= in_ch.center_x[31] ? (~in_ch.center_x + 32'd1) : in_ch.center_x;
      cy_abs_r      <= in_ch.center_y[31] ? (~in_ch.center_y + 32'd1) : in_ch.center_y;
      r_abs_r       <= in_ch.radius;
      rm_ok_r       <= !rm_calc[31];
      rm_abs_r      <= rm_calc[31] ? 32'd0 : rm_calc;
      ex_init_r     <= -EW'(in_ch.center_x);
      ex_r          <= -EW'(in_ch.center_x);
      ey_r          <= -EW'(in_ch.center_y);
      x_r           <= '0;
      y_r           <= '0;
      row_base_r    <= '0;
      clr_addr_r    <= '0;
      sq_idx_r      <= 2'd0;
      if ((in_ch.command == ccp_pkg::CMD_DRAW) && !draw_ok) begin
        res_status_r <= ccp_pkg::STATUS_BAD_SHAPE;
      end else if ((in_ch.command == ccp_pkg::CMD_READ) && !rd_in_range) begin
        res_status_r <= ccp_pkg::STATUS_OUTSIDE;
      end else begin
        res_status_r <= ccp_pkg::STATUS_OK;
      end
    end
    if (state_r == ccp_pkg::ST_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
    if ((state_r == ccp_pkg::ST_SETUP) && sq_rsp.done) begin
      sq_idx_r <= sq_idx_r + 2'd1;
      case (sq_idx_r)
        2'd0: begin
          cx2_r <= sq_rsp.square;
          dx2_r <= sq_rsp.square;
        end
        2'd1:    dy2_r <= sq_rsp.square;
        2'd2:    r2_r  <= sq_rsp.square;
        default: rm2_r <= sq_rsp.square;
      endcase
    end
    if (state_r == ccp_pkg::ST_DRAW) begin
      p_addr_r <= row_base_r + AW'(x_r);
      d2_r     <= {1'b0, dx2_r} + {1'b0, dy2_r};
      if (row_end) begin
        x_r        <= '0;
        ex_r       <= ex_init_r;
        dx2_r      <= cx2_r;
        y_r        <= y_r + YW'(1);
        row_base_r <= row_base_r + AW'(MAX_WIDTH);
        ey_r       <= ey_r + EW'(256);
        dy2_r      <= dy2_nxt;
      end else begin
        x_r   <= x_r + XW'(1);
        ex_r  <= ex_r + EW'(256);
        dx2_r <= dx2_nxt;
      end
    end
    if (res_load) begin
      out_status_r <= res_status_r;
      out_pixel_r  <= res_is_read_r ? rd_data_r : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) canvas_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= canvas_mem[rd_addr_r];
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.pixel_char = out_pixel_r;

endmodule

/* rtl/core/ccp_checker.sv */
// ----------------------------------------------------------------------------
// Circle canvas painter checker
// Port-level assertions on the painter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_canvas_painter_defines.svh"

module ccp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_pixel
);

  `CCP_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `CCP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_pixel), "stalled result changed")
  `CCP_ASSERT(a_status_code, out_valid |-> out_status != 2'd3, "undefined status code")
  `CCP_ASSERT(a_error_pixel_zero, out_valid && out_status != ccp_pkg::STATUS_OK |-> out_pixel == 8'd0, "pixel byte on failed request")
  `CCP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request taken while busy")

endmodule

bind circle_canvas_painter ccp_checker u_ccp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_pixel  (out_ch.pixel_char)
);
